// ===== design/wfba_pkg.sv =====
// Package for the worst-fit block allocator: sizes, field widths, codes
// and the saturating accumulator helper.
// No dependencies.
package wfba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam int IN_SIZE_W  = 16;
    localparam int STATUS_W   = 2;
    localparam int OUT_IDX_W  = 4;
    localparam int SUM_W      = 20;
    localparam int ADD_W      = ((SIZE_BITS > SUM_W) ? SIZE_BITS : SUM_W) + 1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int M_TDATA_W = OUT_IDX_W + 3 * SUM_W;

    typedef logic [SIZE_BITS-1:0] size_t;
    typedef logic [SUM_W-1:0]     sum_t;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_REQUEST = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_LOADED    = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_ALLOCATED = 2'd2,
        STATUS_NOT_ALLOC = 2'd3
    } status_t;

    function automatic sum_t sat_add(input sum_t a, input size_t b);
        logic [ADD_W-1:0] s;
        s = ADD_W'(a) + ADD_W'(b);
        return (s > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
    endfunction

endpackage

// ===== design/wfba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/worst_fit_block_allocator.sv =====
// Worst-fit block allocator top level: sequencer, compare unit and result register.
// Depends on wfba_pkg and wfba_ram.
//
// Usage:
//   Input channel s_*: one transaction per command. s_tuser carries the command
//   (load a partition size or request an allocation), s_tdata the size.
//   Result channel m_*: exactly one transaction per input, carrying status
//   in m_tuser and the chosen/loaded index plus total, used and free memory
//   in m_tdata.
//   Sequencing: a load passes from acceptance through the load and response
//   states to the result register. A request passes through the scan, update
//   and response states: the partition table is a RAM with one registered read
//   port, and the compare unit walks it one entry per cycle, then does the
//   update write. The block takes one item at a time; s_tready is high only
//   while the sequencer is idle, from the cycle after the result is registered.
//   Reset (aresetn low, synchronous) empties the table and clears the sums
//   and the result valid flag. The table RAM itself is not cleared; only
//   loaded entries are ever read.
//   A stalled receiver holds the result in the output register; the block
//   still accepts and works the next item, then waits to hand its result
//   over until the register is free.
module worst_fit_block_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wfba_pkg::IN_SIZE_W-1:0] s_tdata,   // [15:0] size_value
    input  logic [0:0]                    s_tuser,   // [0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wfba_pkg::M_TDATA_W-1:0] m_tdata,  // [3:0] block_index,
                                                     // [23:4] total_memory,
                                                     // [43:24] used_memory,
                                                     // [63:44] free_memory
    output logic [wfba_pkg::STATUS_W-1:0] m_tuser    // [1:0] status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } state_t;

    state_t                         state_reg;
    wfba_pkg::size_t                size_reg;
    logic [wfba_pkg::CNT_W-1:0]     cnt_reg;
    logic [wfba_pkg::CNT_W-1:0]     rd_ptr_reg;
    logic                           pend_reg;
    logic [wfba_pkg::IDX_W-1:0]     cmp_idx_reg;
    logic                           found_reg;
    logic [wfba_pkg::IDX_W-1:0]     best_idx_reg;
    wfba_pkg::size_t                best_val_reg;
    wfba_pkg::sum_t                 total_reg;
    wfba_pkg::sum_t                 used_reg;
    wfba_pkg::status_t              res_status_reg;
    logic [wfba_pkg::IDX_W-1:0]     res_idx_reg;

    logic                           m_valid_reg;
    wfba_pkg::status_t              m_status_reg;
    logic [wfba_pkg::OUT_IDX_W-1:0] m_idx_reg;
    wfba_pkg::sum_t                 m_total_reg;
    wfba_pkg::sum_t                 m_used_reg;
    wfba_pkg::sum_t                 m_free_reg;

    logic                           ram_we;
    logic [wfba_pkg::IDX_W-1:0]     ram_waddr;
    wfba_pkg::size_t                ram_wdata;
    logic [wfba_pkg::IDX_W-1:0]     ram_raddr;
    wfba_pkg::size_t                ram_rdata;

    logic                           table_full;
    logic                           scan_issue;
    logic                           fits;
    wfba_pkg::sum_t                 total_next;
    wfba_pkg::sum_t                 used_next;
    wfba_pkg::sum_t                 free_next;
    wfba_pkg::size_t                size_in;

    assign size_in    = wfba_pkg::SIZE_BITS'(s_tdata);
    assign table_full = (cnt_reg == wfba_pkg::CNT_W'(wfba_pkg::MAX_BLOCKS));
    assign scan_issue = (state_reg == ST_SCAN) && (rd_ptr_reg != cnt_reg);
    assign fits       = (ram_rdata >= size_reg) && (!found_reg || ram_rdata > best_val_reg);
    assign total_next = wfba_pkg::sat_add(total_reg, size_reg);
    assign used_next  = wfba_pkg::sat_add(used_reg, size_reg);
    assign free_next  = (used_reg > total_reg) ? '0 : (total_reg - used_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[wfba_pkg::IDX_W-1:0];
        ram_wdata = size_reg;
        if (state_reg == ST_LOAD && !table_full) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_UPDATE && found_reg) begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_reg;
            ram_wdata = best_val_reg - size_reg;
        end
    end

    assign ram_raddr = rd_ptr_reg[wfba_pkg::IDX_W-1:0];

    wfba_ram #(
        .WIDTH (wfba_pkg::SIZE_BITS),
        .DEPTH (wfba_pkg::MAX_BLOCKS)
    ) u_space_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            total_reg   <= '0;
            used_reg    <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            rd_ptr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the response state reloads the output register itself
            if (m_valid_reg && m_tready && (state_reg != ST_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        size_reg   <= size_in;
                        rd_ptr_reg <= '0;
                        pend_reg   <= 1'b0;
                        found_reg  <= 1'b0;
                        state_reg  <= (s_tuser[0] == wfba_pkg::CMD_LOAD) ? ST_LOAD : ST_SCAN;
                    end
                end
                ST_LOAD: begin
                    if (table_full) begin
                        res_status_reg <= wfba_pkg::STATUS_FULL;
                        res_idx_reg    <= '0;
                    end else begin
                        res_status_reg <= wfba_pkg::STATUS_LOADED;
                        res_idx_reg    <= cnt_reg[wfba_pkg::IDX_W-1:0];
                        cnt_reg        <= cnt_reg + 1'b1;
                        total_reg      <= total_next;
                    end
                    state_reg <= ST_RESP;
                end
                ST_SCAN: begin
                    // read of entry rd_ptr issued now, compared next cycle
                    pend_reg <= scan_issue;
                    if (scan_issue) begin
                        rd_ptr_reg  <= rd_ptr_reg + 1'b1;
                        cmp_idx_reg <= rd_ptr_reg[wfba_pkg::IDX_W-1:0];
                    end
                    if (pend_reg && fits) begin
                        found_reg    <= 1'b1;
                        best_idx_reg <= cmp_idx_reg;
                        best_val_reg <= ram_rdata;
                    end
                    if (!scan_issue && !pend_reg) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (found_reg) begin
                        res_status_reg <= wfba_pkg::STATUS_ALLOCATED;
                        res_idx_reg    <= best_idx_reg;
                        used_reg       <= used_next;
                    end else begin
                        res_status_reg <= wfba_pkg::STATUS_NOT_ALLOC;
                        res_idx_reg    <= '0;
                    end
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_idx_reg    <= wfba_pkg::OUT_IDX_W'(res_idx_reg);
                        m_total_reg  <= total_reg;
                        m_used_reg   <= used_reg;
                        m_free_reg   <= free_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_free_reg, m_used_reg, m_total_reg, m_idx_reg};

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= wfba_pkg::CNT_W'(wfba_pkg::MAX_BLOCKS))
        else $error("loaded count beyond table size");

    a_free_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_total_reg >= m_used_reg) |-> m_free_reg == m_total_reg - m_used_reg)
        else $error("free memory mismatch");

    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == wfba_pkg::STATUS_FULL ||
                        m_status_reg == wfba_pkg::STATUS_NOT_ALLOC) |-> m_idx_reg == '0)
        else $error("nonzero index on failed transaction");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> rd_ptr_reg <= cnt_reg)
        else $error("scan pointer beyond loaded entries");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for worst_fit_block_allocator: directed and random
// load/request traffic checked against an in-bench worst-fit predictor.
// Depends on wfba_pkg and the worst_fit_block_allocator RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_ITEMS  = 1410;
    localparam int PRINT_LIMIT   = 50;
    localparam int SIZE_MAX      = (1 << wfba_pkg::IN_SIZE_W) - 1;

    typedef struct {
        wfba_pkg::status_t              status;
        logic [wfba_pkg::OUT_IDX_W-1:0] index;
        wfba_pkg::sum_t                 total;
        wfba_pkg::sum_t                 used;
        wfba_pkg::sum_t                 free;
    } alloc_result_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [wfba_pkg::IN_SIZE_W-1:0]   s_tdata  = '0;
    logic [0:0]                       s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [wfba_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [wfba_pkg::STATUS_W-1:0]    m_tuser;

    // Predictor state: partition table, fill level and running sums.
    wfba_pkg::size_t        part_space [wfba_pkg::MAX_BLOCKS];
    int                     parts_loaded = 0;
    wfba_pkg::sum_t         mem_total    = '0;
    wfba_pkg::sum_t         mem_used     = '0;
    alloc_result_t          pending_results [$];

    int                     mismatch_count = 0;
    int                     burst_left     = 0;
    bit                     offering       = 1'b0;
    int                     rx_hold_len    = 0;
    int                     idle_cycles    = 0;

    worst_fit_block_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string field, input longint unsigned want,
                                   input longint unsigned got);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
        mismatch_count++;
    endtask

    function automatic wfba_pkg::sum_t add_clamped(input wfba_pkg::sum_t acc,
                                                   input wfba_pkg::size_t amount);
        longint unsigned s;
        s = 64'(acc) + 64'(amount);
        return (s > 64'(wfba_pkg::SUM_MAX)) ? wfba_pkg::SUM_MAX : wfba_pkg::sum_t'(s);
    endfunction

    // Largest remaining space among loaded partitions, -1 on an empty table.
    function automatic int largest_space();
        int top;
        top = -1;
        for (int j = 0; j < parts_loaded; j++) begin
            if (int'(part_space[j]) > top) begin
                top = int'(part_space[j]);
            end
        end
        return top;
    endfunction

    function automatic void predict_allocation(input wfba_pkg::cmd_t cmd,
                                               input logic [wfba_pkg::IN_SIZE_W-1:0] raw);
        alloc_result_t   r;
        wfba_pkg::size_t amount;
        int              best;
        amount = wfba_pkg::size_t'(raw);
        best   = -1;
        r.index = '0;
        if (cmd == wfba_pkg::CMD_LOAD) begin
            if (parts_loaded >= wfba_pkg::MAX_BLOCKS) begin
                r.status = wfba_pkg::STATUS_FULL;
            end else begin
                part_space[parts_loaded] = amount;
                r.index   = wfba_pkg::OUT_IDX_W'(parts_loaded);
                r.status  = wfba_pkg::STATUS_LOADED;
                mem_total = add_clamped(mem_total, amount);
                parts_loaded++;
            end
        end else begin
            // Worst fit: strict compare keeps the lowest index on a tie.
            for (int j = 0; j < parts_loaded; j++) begin
                if (part_space[j] >= amount && (best < 0 || part_space[j] > part_space[best])) begin
                    best = j;
                end
            end
            if (best < 0) begin
                r.status = wfba_pkg::STATUS_NOT_ALLOC;
            end else begin
                part_space[best] = part_space[best] - amount;
                mem_used = add_clamped(mem_used, amount);
                r.index  = wfba_pkg::OUT_IDX_W'(best);
                r.status = wfba_pkg::STATUS_ALLOCATED;
            end
        end
        r.total = mem_total;
        r.used  = mem_used;
        r.free  = (mem_used > mem_total) ? '0 : mem_total - mem_used;
        pending_results.push_back(r);
    endfunction

    task automatic send_item(input wfba_pkg::cmd_t cmd,
                             input logic [wfba_pkg::IN_SIZE_W-1:0] size_value);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= size_value;
        offering = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_allocation(cmd, size_value);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
    endtask

    task automatic send_random_item();
        int   top;
        int   pick;
        logic [wfba_pkg::IN_SIZE_W-1:0] size_value;
        top  = largest_space();
        pick = $urandom_range(0, 99);
        if ((parts_loaded < wfba_pkg::MAX_BLOCKS && $urandom_range(0, 5) == 0) ||
            (parts_loaded >= wfba_pkg::MAX_BLOCKS && $urandom_range(0, 24) == 0)) begin
            if (parts_loaded > 0 && pick < 25) begin
                // repeat an existing space to set up ties
                size_value = part_space[$urandom_range(0, parts_loaded - 1)];
            end else if (pick < 50) begin
                size_value = wfba_pkg::IN_SIZE_W'($urandom_range(0, 15));
            end else begin
                size_value = wfba_pkg::IN_SIZE_W'($urandom_range(0, SIZE_MAX));
            end
            send_item(wfba_pkg::CMD_LOAD, size_value);
        end else begin
            if (top < 0) begin
                size_value = wfba_pkg::IN_SIZE_W'($urandom_range(0, SIZE_MAX));
            end else if (pick < 3) begin
                size_value = wfba_pkg::IN_SIZE_W'(top);
            end else if (pick < 6) begin
                size_value = wfba_pkg::IN_SIZE_W'($urandom_range(0, top));
            end else if (pick < 16) begin
                size_value = wfba_pkg::IN_SIZE_W'((top >= SIZE_MAX) ? SIZE_MAX : top + 1);
            end else if (pick < 24) begin
                size_value = '0;
            end else if (pick < 34) begin
                size_value = wfba_pkg::IN_SIZE_W'($urandom_range(0, SIZE_MAX));
            end else if (pick < 44) begin
                size_value = wfba_pkg::IN_SIZE_W'($urandom_range(0, 3));
            end else begin
                size_value = wfba_pkg::IN_SIZE_W'($urandom_range(0, top >> 5));
            end
            send_item(wfba_pkg::CMD_REQUEST, size_value);
        end
    endtask

    // Drop the offer, wait for every expected result, then let the block settle.
    task automatic settle();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_empty_table();
        send_item(wfba_pkg::CMD_REQUEST, '0);
        send_item(wfba_pkg::CMD_REQUEST, wfba_pkg::IN_SIZE_W'(SIZE_MAX));
        settle();
    endtask

    task automatic test_load_extremes();
        send_item(wfba_pkg::CMD_LOAD, wfba_pkg::IN_SIZE_W'(SIZE_MAX));
        send_item(wfba_pkg::CMD_LOAD, '0);
        send_item(wfba_pkg::CMD_LOAD, 16'd1);
        send_item(wfba_pkg::CMD_LOAD, 16'd40000);
        send_item(wfba_pkg::CMD_LOAD, 16'd40000);
        send_item(wfba_pkg::CMD_LOAD, 16'h5AA5);
        settle();
    endtask

    task automatic test_worst_fit_requests();
        send_item(wfba_pkg::CMD_REQUEST, '0);
        send_item(wfba_pkg::CMD_REQUEST, wfba_pkg::IN_SIZE_W'(SIZE_MAX));
        send_item(wfba_pkg::CMD_REQUEST, '0);
        send_item(wfba_pkg::CMD_REQUEST, 16'd40001);
        send_item(wfba_pkg::CMD_REQUEST, 16'd40000);
        send_item(wfba_pkg::CMD_REQUEST, 16'd1);
        send_item(wfba_pkg::CMD_REQUEST, wfba_pkg::IN_SIZE_W'(SIZE_MAX));
        settle();
    endtask

    task automatic test_backpressure();
        rx_hold_len = HOLD_CYCLES;
        burst_left  = 40;
        repeat (16) send_random_item();
        settle();
    endtask

    task automatic test_random_traffic();
        repeat (RANDOM_ITEMS) send_random_item();
        settle();
    endtask

    task automatic test_table_full();
        while (parts_loaded < wfba_pkg::MAX_BLOCKS) begin
            send_item(wfba_pkg::CMD_LOAD, wfba_pkg::IN_SIZE_W'($urandom_range(0, SIZE_MAX)));
        end
        send_item(wfba_pkg::CMD_LOAD, wfba_pkg::IN_SIZE_W'(SIZE_MAX));
        send_item(wfba_pkg::CMD_LOAD, '0);
        send_item(wfba_pkg::CMD_REQUEST, '0);
        settle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        burst_left = $urandom_range(1, 24);
        test_empty_table();
        test_load_extremes();
        test_worst_fit_requests();
        test_backpressure();
        test_random_traffic();
        test_table_full();
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Result side: random stall modes, plus a long hold-off on request.
    always @(posedge aclk) begin : result_receiver
        int       hold_left;
        int       mode_left;
        rx_mode_t rx_mode;
        logic [7:0] stall_pattern;
        if (rx_hold_len > 0) begin
            hold_left   = rx_hold_len;
            rx_hold_len = 0;
        end
        if (stall_pattern == 8'h00 || $isunknown(stall_pattern)) begin
            stall_pattern = 8'b1011_0010;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left <= 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            case (rx_mode)
                RX_ALWAYS: begin
                    m_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                RX_SPARSE: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= stall_pattern[0];
                end
            endcase
        end
    end

    always @(posedge aclk) begin : result_checker
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", '0, 64'(m_tuser));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    report_mismatch("status", 64'(want.status), 64'(m_tuser));
                end
                if (m_tdata[wfba_pkg::OUT_IDX_W-1:0] !== want.index) begin
                    report_mismatch("block_index", 64'(want.index),
                                    64'(m_tdata[wfba_pkg::OUT_IDX_W-1:0]));
                end
                if (m_tdata[wfba_pkg::OUT_IDX_W +: wfba_pkg::SUM_W] !== want.total) begin
                    report_mismatch("total_memory", 64'(want.total),
                                    64'(m_tdata[wfba_pkg::OUT_IDX_W +: wfba_pkg::SUM_W]));
                end
                if (m_tdata[wfba_pkg::OUT_IDX_W + wfba_pkg::SUM_W +: wfba_pkg::SUM_W]
                    !== want.used) begin
                    report_mismatch("used_memory", 64'(want.used),
                        64'(m_tdata[wfba_pkg::OUT_IDX_W + wfba_pkg::SUM_W +: wfba_pkg::SUM_W]));
                end
                if (m_tdata[wfba_pkg::OUT_IDX_W + 2 * wfba_pkg::SUM_W +: wfba_pkg::SUM_W]
                    !== want.free) begin
                    report_mismatch("free_memory", 64'(want.free),
                        64'(m_tdata[wfba_pkg::OUT_IDX_W + 2 * wfba_pkg::SUM_W
                                    +: wfba_pkg::SUM_W]));
                end
            end
        end
    end

    // Abort when no transaction moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

endmodule
